/* src/flrq_pkg.sv */
// package for the fair reentrant lock queue: field widths and status codes
`timescale 1ns / 1ps
`default_nettype none
package flrq_pkg;

  // requester id width
  localparam int ID_W = 4;

  // result status field
  localparam int STATUS_W = 3;
  localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LOWERED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_OWNER = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;
  localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd6;

  // request commands
  localparam logic CMD_LOCK   = 1'b0;
  localparam logic CMD_UNLOCK = 1'b1;

  // result field widths
  localparam int DEPTH_W = 16;
  localparam int QCOUNT_W = 5;

  // stream widths
  localparam int IN_W  = 8;
  localparam int OUT_W = 40;

endpackage
`default_nettype wire

/* src/fair_reentrant_lock_queue_top.sv */
// top level of the fair reentrant lock queue
`timescale 1ns / 1ps
`default_nettype none
// Fair reentrant lock unit. Each input item is a lock or unlock request from
// a requester id; each produces exactly one result item with a status, the
// owner after the request, its hold depth, any waiter that was just granted
// the lock, and the queue occupancy. Waiting ids live in a ring memory whose
// head entry is the owner; the owner id is also kept in a register. Most
// requests are evaluated combinationally into the output register: a new item
// is accepted whenever the sequencer is idle and the output register is empty
// or being drained. An unlock that hands the lock to the next waiter passes
// through the wake state, since the new owner's id is read from the ring
// memory's registered read port. No clearing pass is needed after reset.
module fair_reentrant_lock_queue_top
  import flrq_pkg::*;
#(
  parameter int              QUEUE_DEPTH = 16,
  parameter longint unsigned MAX_HOLD    = 65535
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // [0] cmd, [4:1] requester, [7:5] zero
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // [2:0] status, [3] owner_valid, [7:4] owner_id, [23:8] depth,
  // [24] woken_valid, [28:25] woken_id, [33:29] queue_count, [39:34] zero
  output logic      [OUT_W-1:0] m_axis_tdata
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int HOLD_W = $clog2(MAX_HOLD + 64'd1);

  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [HOLD_W-1:0] HOLD_MAX = HOLD_W'(MAX_HOLD);
  localparam logic [HOLD_W-1:0] HOLD_ONE = HOLD_W'(1);

  // sequencer states
  localparam logic S_IDLE = 1'b0;
  localparam logic S_WAKE = 1'b1;

  logic              state, state_next;
  logic [PTR_W-1:0]  head, head_next;
  logic [PTR_W-1:0]  tail, tail_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [HOLD_W-1:0] hold, hold_next;
  logic [ID_W-1:0]   owner, owner_next;
  logic              out_valid, out_valid_next;
  logic [OUT_W-1:0]  out_data, out_data_next;

  logic              wr_en, rd_en;
  logic [ID_W-1:0]   rd_data;

  logic              in_accept;
  logic              cmd;
  logic [ID_W-1:0]   who;
  logic              is_owner;
  logic [PTR_W-1:0]  head_inc, tail_inc;
  logic [STATUS_W-1:0] status;
  logic              load_out;

  // ring of waiting ids
  flrq_ring #(
    .DEPTH (QUEUE_DEPTH),
    .PTR_W (PTR_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (who),
    .rd_en   (rd_en),
    .rd_addr (head_inc),
    .rd_data (rd_data)
  );

  // input handshake and unpacking
  assign s_axis_tready = (state == S_IDLE) && (!out_valid || m_axis_tready);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cmd           = s_axis_tdata[0];
  assign who           = s_axis_tdata[ID_W:1];
  assign is_owner      = (count != '0) && (owner == who);
  assign head_inc      = (head == PTR_LAST) ? '0 : head + PTR_W'(1);
  assign tail_inc      = (tail == PTR_LAST) ? '0 : tail + PTR_W'(1);

  // request evaluation
  always_comb begin
    state_next     = state;
    head_next      = head;
    tail_next      = tail;
    count_next     = count;
    hold_next      = hold;
    owner_next     = owner;
    out_valid_next = out_valid && !m_axis_tready;
    out_data_next  = out_data;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    status         = ST_GRANTED;
    load_out       = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_accept) begin
          load_out = 1'b1;
          if (cmd == CMD_LOCK) begin
            if (is_owner) begin
              if (hold == HOLD_MAX) begin
                status = ST_SATURATED;
              end else begin
                hold_next = hold + HOLD_ONE;
                status    = ST_GRANTED;
              end
            end else if (count == CNT_FULL) begin
              status = ST_FULL;
            end else begin
              wr_en      = 1'b1;
              tail_next  = tail_inc;
              count_next = count + CNT_W'(1);
              if (count == '0) begin
                hold_next  = HOLD_ONE;
                owner_next = who;
                status     = ST_GRANTED;
              end else begin
                status = ST_QUEUED;
              end
            end
          end else begin
            if (!is_owner) begin
              status = ST_NOT_OWNER;
            end else if (hold > HOLD_ONE) begin
              hold_next = hold - HOLD_ONE;
              status    = ST_LOWERED;
            end else begin
              head_next  = head_inc;
              count_next = count - CNT_W'(1);
              hold_next  = '0;
              status     = ST_RELEASED;
              if (count != CNT_W'(1)) begin
                // next waiter's id comes back from the ring next cycle
                hold_next  = HOLD_ONE;
                rd_en      = 1'b1;
                load_out   = 1'b0;
                state_next = S_WAKE;
              end
            end
          end
        end
        if (load_out) begin
          out_valid_next = 1'b1;
          out_data_next  = {6'd0,
                            QCOUNT_W'(count_next),
                            {ID_W{1'b0}},
                            1'b0,
                            DEPTH_W'(hold_next),
                            (count_next != '0) ? owner_next : {ID_W{1'b0}},
                            (count_next != '0),
                            status};
        end
      end
      S_WAKE: begin
        // hand the lock to the waiter read from the ring
        owner_next     = rd_data;
        out_valid_next = 1'b1;
        out_data_next  = {6'd0,
                          QCOUNT_W'(count),
                          rd_data,
                          1'b1,
                          DEPTH_W'(hold),
                          rd_data,
                          1'b1,
                          ST_RELEASED};
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      hold      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      hold      <= hold_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    owner    <= owner_next;
    out_data <= out_data_next;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule
`default_nettype wire

/* src/flrq_ring.sv */
// ring memory of waiting requester ids, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module flrq_ring
  import flrq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int PTR_W = 4
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [PTR_W-1:0] wr_addr,
  input  wire logic [ID_W-1:0]  wr_data,
  input  wire logic             rd_en,
  input  wire logic [PTR_W-1:0] rd_addr,
  output logic      [ID_W-1:0]  rd_data
);

  logic [ID_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data registered and valid in the cycle after the address
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire
